// ----- rtl/core/dcmt_pkg.sv -----
// Shared types and constants for the double-clench mode toggle.
// No dependencies; compile first.
package dcmt_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int COORD_WIDTH = 16;
    localparam int WINDOW_WIDTH = 16;
    localparam int CMP_WIDTH = (TIMER_WIDTH > WINDOW_WIDTH) ? TIMER_WIDTH : WINDOW_WIDTH;
    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 16'd1000;

    typedef enum logic [2:0] {
        KIND_TICK     = 3'd0,
        KIND_OPEN     = 3'd1,
        KIND_CLOSE    = 3'd2,
        KIND_HAND_POS = 3'd3,
        KIND_HEAD_POS = 3'd4,
        KIND_INTR     = 3'd5,
        KIND_ATTACH   = 3'd6,
        KIND_DETACH   = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        BTN_NONE    = 2'd0,
        BTN_PRESS   = 2'd1,
        BTN_RELEASE = 2'd2
    } t_btn_ev;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_CLOSE1 = 2'd1,
        PH_OPEN1  = 2'd2,
        PH_CLOSE2 = 2'd3
    } t_phase;

    typedef struct packed {
        t_kind                          kind;
        logic signed [COORD_WIDTH-1:0]  pos_x;
        logic signed [COORD_WIDTH-1:0]  pos_y;
    } t_item;

    typedef struct packed {
        logic                           cursor_valid;
        logic signed [COORD_WIDTH-1:0]  cursor_x;
        logic signed [COORD_WIDTH-1:0]  cursor_y;
        t_btn_ev                        button_event;
        logic                           hand_mode;
        logic                           enabled;
    } t_result;

endpackage

// ----- rtl/core/dcmt_in_if.sv -----
// Event input channel: valid/ready handshake with kind and coordinates.
// Depends on dcmt_pkg.
interface dcmt_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [2:0]                              kind;
    logic signed [dcmt_pkg::COORD_WIDTH-1:0] pos_x;
    logic signed [dcmt_pkg::COORD_WIDTH-1:0] pos_y;

    modport source (output valid, output kind, output pos_x, output pos_y, input ready);
    modport sink (input valid, input kind, input pos_x, input pos_y, output ready);
endinterface

// ----- rtl/core/dcmt_out_if.sv -----
// Result output channel: valid/ready handshake with cursor and button fields.
// Depends on dcmt_pkg.
interface dcmt_out_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    cursor_valid;
    logic signed [dcmt_pkg::COORD_WIDTH-1:0] cursor_x;
    logic signed [dcmt_pkg::COORD_WIDTH-1:0] cursor_y;
    logic [1:0]                              button_event;
    logic                                    hand_mode;
    logic                                    enabled;

    modport source (
        output valid, output cursor_valid, output cursor_x, output cursor_y,
        output button_event, output hand_mode, output enabled, input ready
    );
    modport sink (
        input valid, input cursor_valid, input cursor_x, input cursor_y,
        input button_event, input hand_mode, input enabled, output ready
    );
endinterface

// ----- rtl/core/dcmt_in_stage.sv -----
// Input register: captures one event transaction per cycle while it is empty or its held item is taken.
// Depends on dcmt_pkg and dcmt_in_if.
module dcmt_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dcmt_in_if.sink           i_evt,
    input  logic              i_take,
    output logic              o_valid,
    output dcmt_pkg::t_item   o_item
);

    logic            r_valid;
    dcmt_pkg::t_item r_item;
    logic            w_load;

    assign i_evt.ready = !r_valid || i_take;
    assign w_load      = i_evt.valid && i_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (w_load) begin
            r_item.kind  <= dcmt_pkg::t_kind'(i_evt.kind);
            r_item.pos_x <= i_evt.pos_x;
            r_item.pos_y <= i_evt.pos_y;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/core/dcmt_core.sv -----
// Gesture state, mode, button and elapsed timer; computes one result per item.
// Depends on dcmt_pkg.
module dcmt_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [dcmt_pkg::WINDOW_WIDTH-1:0]      i_cfg_wdata,
    input  logic                                   i_take,
    input  dcmt_pkg::t_item                        i_item,
    output dcmt_pkg::t_result                      o_result
);

    logic                                  r_attached, n_attached;
    dcmt_pkg::t_phase                      r_phase, n_phase;
    logic                                  r_hand, n_hand;
    logic                                  r_btn, n_btn;
    logic [dcmt_pkg::TIMER_WIDTH-1:0]      r_elapsed, n_elapsed;
    logic [dcmt_pkg::WINDOW_WIDTH-1:0]     r_window;
    logic                                  w_in_time;
    dcmt_pkg::t_result                     w_res;

    assign w_in_time = dcmt_pkg::CMP_WIDTH'(r_elapsed) < dcmt_pkg::CMP_WIDTH'(r_window);

    always_comb begin
        n_attached = r_attached;
        n_phase    = r_phase;
        n_hand     = r_hand;
        n_btn      = r_btn;
        n_elapsed  = r_elapsed;
        w_res      = '0;
        w_res.button_event = dcmt_pkg::BTN_NONE;

        if (i_item.kind == dcmt_pkg::KIND_TICK) begin
            if (r_elapsed != '1) begin
                n_elapsed = r_elapsed + 1'b1;
            end
        end else if (i_item.kind == dcmt_pkg::KIND_ATTACH) begin
            if (!r_attached) begin
                if (r_btn) begin
                    w_res.button_event = dcmt_pkg::BTN_RELEASE;
                end
                n_btn      = 1'b0;
                n_phase    = dcmt_pkg::PH_IDLE;
                n_hand     = 1'b0;
                n_attached = 1'b1;
            end
        end else if (r_attached) begin
            unique case (i_item.kind) inside
                dcmt_pkg::KIND_OPEN: begin
                    if (r_hand) begin
                        if (r_btn) begin
                            n_btn = 1'b0;
                            w_res.button_event = dcmt_pkg::BTN_RELEASE;
                        end
                    end else if (r_phase == dcmt_pkg::PH_CLOSE1) begin
                        if (w_in_time) begin
                            n_elapsed = '0;
                            n_phase   = dcmt_pkg::PH_OPEN1;
                        end else begin
                            n_phase = dcmt_pkg::PH_IDLE;
                        end
                    end else if (r_phase == dcmt_pkg::PH_OPEN1) begin
                        if (!w_in_time) begin
                            n_phase = dcmt_pkg::PH_IDLE;
                        end
                    end else if (r_phase == dcmt_pkg::PH_CLOSE2) begin
                        if (w_in_time) begin
                            n_hand = 1'b1;
                        end
                        n_phase = dcmt_pkg::PH_IDLE;
                    end
                end
                dcmt_pkg::KIND_CLOSE: begin
                    if (r_hand) begin
                        if (!r_btn) begin
                            n_btn = 1'b1;
                            w_res.button_event = dcmt_pkg::BTN_PRESS;
                        end
                    end else if (r_phase == dcmt_pkg::PH_IDLE) begin
                        n_elapsed = '0;
                        n_phase   = dcmt_pkg::PH_CLOSE1;
                    end else if (r_phase == dcmt_pkg::PH_OPEN1) begin
                        if (w_in_time) begin
                            n_elapsed = '0;
                            n_phase   = dcmt_pkg::PH_CLOSE2;
                        end else begin
                            n_phase = dcmt_pkg::PH_IDLE;
                        end
                    end else if (!w_in_time) begin
                        n_phase = dcmt_pkg::PH_IDLE;
                    end
                end
                dcmt_pkg::KIND_HAND_POS: begin
                    if (r_hand) begin
                        w_res.cursor_valid = 1'b1;
                        w_res.cursor_x     = i_item.pos_x;
                        w_res.cursor_y     = i_item.pos_y;
                    end
                end
                dcmt_pkg::KIND_HEAD_POS: begin
                    if (!r_hand) begin
                        w_res.cursor_valid = 1'b1;
                        w_res.cursor_x     = i_item.pos_x;
                        w_res.cursor_y     = i_item.pos_y;
                    end
                end
                dcmt_pkg::KIND_INTR, dcmt_pkg::KIND_DETACH,
                dcmt_pkg::KIND_TICK, dcmt_pkg::KIND_ATTACH: begin
                    if (r_btn) begin
                        w_res.button_event = dcmt_pkg::BTN_RELEASE;
                    end
                    n_btn   = 1'b0;
                    n_phase = dcmt_pkg::PH_IDLE;
                    n_hand  = 1'b0;
                    if (i_item.kind == dcmt_pkg::KIND_DETACH) begin
                        n_attached = 1'b0;
                    end
                end
            endcase
        end

        w_res.hand_mode = n_hand;
        w_res.enabled   = n_attached;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attached <= 1'b1;
            r_phase    <= dcmt_pkg::PH_IDLE;
            r_hand     <= 1'b0;
            r_btn      <= 1'b0;
            r_elapsed  <= '0;
            r_window   <= dcmt_pkg::WINDOW_RESET;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (i_take) begin
                r_attached <= n_attached;
                r_phase    <= n_phase;
                r_hand     <= n_hand;
                r_btn      <= n_btn;
                r_elapsed  <= n_elapsed;
            end
        end
    end

    assign o_result = w_res;

    a_btn_needs_hand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_btn |-> r_hand)
        else $error("button held outside hand mode");

    a_hand_phase_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hand |-> (r_phase == dcmt_pkg::PH_IDLE))
        else $error("gesture phase active in hand mode");

    a_detached_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_attached |-> (!r_hand && !r_btn && r_phase == dcmt_pkg::PH_IDLE))
        else $error("detached without default state");

endmodule

// ----- rtl/core/dcmt_out_stage.sv -----
// Result register: holds one result transaction until the sink takes it.
// Depends on dcmt_pkg and dcmt_out_if.
module dcmt_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  dcmt_pkg::t_result   i_result,
    output logic                o_free,
    dcmt_out_if.source          o_res
);

    logic              r_valid;
    dcmt_pkg::t_result r_res;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.cursor_valid = r_res.cursor_valid;
    assign o_res.cursor_x     = r_res.cursor_x;
    assign o_res.cursor_y     = r_res.cursor_y;
    assign o_res.button_event = r_res.button_event;
    assign o_res.hand_mode    = r_res.hand_mode;
    assign o_res.enabled      = r_res.enabled;

    a_press_in_hand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.button_event == dcmt_pkg::BTN_PRESS) |-> r_res.hand_mode)
        else $error("press reported outside hand mode");

    a_idle_cursor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.cursor_valid) |-> (r_res.cursor_x == '0 && r_res.cursor_y == '0))
        else $error("cursor coordinates without cursor move");

    a_mode_implies_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.hand_mode) |-> r_res.enabled)
        else $error("hand mode reported while detached");

endmodule

// ----- rtl/core/double_clench_mode_toggle.sv -----
// Double-clench mode toggle: gesture-driven head/hand pointer switch.
// Path: an accepted transaction is registered in the input stage; its result is registered in the output stage.
// Throughput: one transaction per cycle while the output stage is free, set by the single state-update stage.
// Reset: synchronous, active low; returns attached, head mode, idle gesture, window 1000.
// Depends on dcmt_pkg, dcmt_in_if, dcmt_out_if, dcmt_in_stage, dcmt_core, dcmt_out_stage.
module double_clench_mode_toggle (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dcmt_pkg::WINDOW_WIDTH-1:0]   i_cfg_wdata,
    dcmt_in_if.sink                             i_evt,
    dcmt_out_if.source                          o_res
);

    logic              w_in_valid;
    dcmt_pkg::t_item   w_item;
    dcmt_pkg::t_result w_result;
    logic              w_out_free;
    logic              w_take;

    assign w_take = w_in_valid && w_out_free;

    dcmt_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (i_evt),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    dcmt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (w_take),
        .i_item      (w_item),
        .o_result    (w_result)
    );

    dcmt_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_res    (o_res)
    );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for double_clench_mode_toggle: gesture, button, cursor and detach.
// Depends on dcmt_pkg, dcmt_in_if, dcmt_out_if and the RTL under rtl/core.
module tb;
    import dcmt_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [WINDOW_WIDTH-1:0] i_cfg_wdata;

    dcmt_in_if  evt_if ();
    dcmt_out_if res_if ();

    double_clench_mode_toggle u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_evt       (evt_if),
        .o_res       (res_if)
    );

    always #6 i_clk = ~i_clk;

    t_item   gesture_events[$];
    t_result expected_reports[$];
    int      queued_count = 0;
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      no_stall = 1'b0;

    logic [WINDOW_WIDTH-1:0] win_ticks;
    logic                    is_attached;
    t_phase                  gest_phase;
    logic                    in_hand;
    logic                    btn_held;
    logic [TIMER_WIDTH-1:0]  tick_count;

    function automatic t_btn_ev drop_to_default();
        t_btn_ev ev;
        ev = BTN_NONE;
        if (btn_held) begin
            btn_held = 1'b0;
            ev = BTN_RELEASE;
        end
        gest_phase = PH_IDLE;
        in_hand = 1'b0;
        return ev;
    endfunction

    function automatic t_result gesture_step(t_item it);
        t_result r;
        logic    on_time;
        r = '0;
        on_time = tick_count < win_ticks;
        case (it.kind)
            KIND_TICK: begin
                if (tick_count != '1) tick_count++;
            end
            KIND_ATTACH: begin
                if (!is_attached) begin
                    r.button_event = drop_to_default();
                    is_attached = 1'b1;
                end
            end
            default: begin
                if (is_attached) begin
                    case (it.kind)
                        KIND_OPEN: begin
                            if (in_hand) begin
                                if (btn_held) begin
                                    btn_held = 1'b0;
                                    r.button_event = BTN_RELEASE;
                                end
                            end else begin
                                case (gest_phase)
                                    PH_CLOSE1: begin
                                        if (on_time) begin
                                            tick_count = '0;
                                            gest_phase = PH_OPEN1;
                                        end else begin
                                            gest_phase = PH_IDLE;
                                        end
                                    end
                                    PH_OPEN1: begin
                                        if (!on_time) gest_phase = PH_IDLE;
                                    end
                                    PH_CLOSE2: begin
                                        if (on_time) in_hand = 1'b1;
                                        gest_phase = PH_IDLE;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        KIND_CLOSE: begin
                            if (in_hand) begin
                                if (!btn_held) begin
                                    btn_held = 1'b1;
                                    r.button_event = BTN_PRESS;
                                end
                            end else begin
                                case (gest_phase)
                                    PH_IDLE: begin
                                        tick_count = '0;
                                        gest_phase = PH_CLOSE1;
                                    end
                                    PH_OPEN1: begin
                                        if (on_time) begin
                                            tick_count = '0;
                                            gest_phase = PH_CLOSE2;
                                        end else begin
                                            gest_phase = PH_IDLE;
                                        end
                                    end
                                    default: begin
                                        if (!on_time) gest_phase = PH_IDLE;
                                    end
                                endcase
                            end
                        end
                        KIND_HAND_POS: begin
                            if (in_hand) begin
                                r.cursor_valid = 1'b1;
                                r.cursor_x = it.pos_x;
                                r.cursor_y = it.pos_y;
                            end
                        end
                        KIND_HEAD_POS: begin
                            if (!in_hand) begin
                                r.cursor_valid = 1'b1;
                                r.cursor_x = it.pos_x;
                                r.cursor_y = it.pos_y;
                            end
                        end
                        KIND_INTR: begin
                            r.button_event = drop_to_default();
                        end
                        default: begin
                            r.button_event = drop_to_default();
                            is_attached = 1'b0;
                        end
                    endcase
                end
            end
        endcase
        r.hand_mode = in_hand;
        r.enabled = is_attached;
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic void put(t_kind k, logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y);
        t_item it;
        it.kind = k;
        it.pos_x = x;
        it.pos_y = y;
        gesture_events.push_back(it);
        queued_count++;
    endfunction

    task automatic drain();
        while (gesture_events.size() != 0 || expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_window(logic [WINDOW_WIDTH-1:0] w);
        drain();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        win_ticks = w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_gesture(int w);
        int    k;
        t_kind pick;
        for (int s = 0; s < 4; s++) begin
            put((s % 2 == 0) ? KIND_CLOSE : KIND_OPEN, rand_coord(), rand_coord());
            if (s < 3) begin
                if (w <= 40 && $urandom_range(5) == 0) begin
                    k = (w > 0 && $urandom_range(1) == 0) ? w - 1 : w;
                end else begin
                    k = $urandom_range((w < 8) ? ((w > 0) ? w - 1 : 1) : 7);
                end
                repeat (k) put(KIND_TICK, rand_coord(), rand_coord());
            end
        end
        repeat ($urandom_range(3, 10)) begin
            case ($urandom_range(5))
                0, 1:    pick = KIND_CLOSE;
                2:       pick = KIND_OPEN;
                3:       pick = KIND_HAND_POS;
                4:       pick = KIND_HEAD_POS;
                default: pick = KIND_TICK;
            endcase
            put(pick, rand_coord(), rand_coord());
        end
    endtask

    task automatic queue_random(int w, int n);
        int    stop;
        int    r;
        t_kind k;
        stop = queued_count + n;
        while (queued_count < stop) begin
            r = $urandom_range(99);
            if (r < 55) begin
                queue_gesture(w);
            end else if (r < 80) begin
                repeat (3) put(t_kind'($urandom_range(7)), rand_coord(), rand_coord());
            end else if (r < 92) begin
                put(KIND_DETACH, rand_coord(), rand_coord());
                repeat ($urandom_range(1, 4)) begin
                    k = t_kind'($urandom_range(7));
                    if (k == KIND_ATTACH) k = KIND_DETACH;
                    put(k, rand_coord(), rand_coord());
                end
                put(KIND_ATTACH, rand_coord(), rand_coord());
            end else begin
                put(KIND_INTR, rand_coord(), rand_coord());
            end
        end
    endtask

    // Driver: hold the offered transaction until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_if.valid <= 1'b0;
        end else begin
            if (evt_if.valid && evt_if.ready) begin
                expected_reports.push_back(gesture_step(gesture_events.pop_front()));
            end
            if (!evt_if.valid || evt_if.ready) begin
                if (gesture_events.size() != 0 && (no_stall || $urandom_range(99) >= 26)) begin
                    evt_if.valid <= 1'b1;
                    evt_if.kind  <= gesture_events[0].kind;
                    evt_if.pos_x <= gesture_events[0].pos_x;
                    evt_if.pos_y <= gesture_events[0].pos_y;
                end else begin
                    evt_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= no_stall || $urandom_range(99) >= 26;
            if (res_if.valid && res_if.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result transaction");
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("cursor_valid", want.cursor_valid, res_if.cursor_valid);
                    check_field("cursor_x", want.cursor_x, res_if.cursor_x);
                    check_field("cursor_y", want.cursor_y, res_if.cursor_y);
                    check_field("button_event", want.button_event, res_if.button_event);
                    check_field("hand_mode", want.hand_mode, res_if.hand_mode);
                    check_field("enabled", want.enabled, res_if.enabled);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        evt_if.valid = 1'b0;
        evt_if.kind = KIND_TICK;
        evt_if.pos_x = '0;
        evt_if.pos_y = '0;
        res_if.ready = 1'b0;
        win_ticks = WINDOW_RESET;
        is_attached = 1'b1;
        gest_phase = PH_IDLE;
        in_hand = 1'b0;
        btn_held = 1'b0;
        tick_count = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        put(KIND_TICK, '0, '0);
        put(KIND_HEAD_POS, 16'h8000, 16'h7FFF);
        put(KIND_HEAD_POS, 16'h7FFF, 16'h8000);
        put(KIND_HAND_POS, 16'h0001, 16'hFFFF);
        put(KIND_CLOSE, '0, '0);
        put(KIND_TICK, '0, '0);
        put(KIND_OPEN, '0, '0);
        put(KIND_CLOSE, '0, '0);
        put(KIND_OPEN, '0, '0);
        put(KIND_HAND_POS, 16'h7FFF, 16'h7FFF);
        put(KIND_HEAD_POS, 16'h1234, 16'h5678);
        put(KIND_CLOSE, '0, '0);
        put(KIND_CLOSE, '0, '0);
        put(KIND_OPEN, '0, '0);
        put(KIND_OPEN, '0, '0);
        put(KIND_CLOSE, '0, '0);
        put(KIND_INTR, '0, '0);
        put(KIND_DETACH, '0, '0);
        put(KIND_CLOSE, '0, '0);
        put(KIND_HEAD_POS, 16'h00FF, 16'hFF00);
        put(KIND_INTR, '0, '0);
        put(KIND_DETACH, '0, '0);
        put(KIND_TICK, '0, '0);
        put(KIND_ATTACH, '0, '0);
        put(KIND_ATTACH, '0, '0);

        set_window(16'd2);
        put(KIND_CLOSE, '0, '0);
        put(KIND_OPEN, '0, '0);
        put(KIND_CLOSE, '0, '0);
        put(KIND_CLOSE, '0, '0);
        put(KIND_TICK, '0, '0);
        put(KIND_TICK, '0, '0);
        put(KIND_CLOSE, '0, '0);
        put(KIND_CLOSE, '0, '0);
        put(KIND_OPEN, '0, '0);
        put(KIND_OPEN, '0, '0);
        put(KIND_TICK, '0, '0);
        put(KIND_TICK, '0, '0);
        put(KIND_OPEN, '0, '0);

        set_window(16'd1);
        queue_random(1, 260);
        set_window(16'd0);
        queue_random(0, 200);
        set_window(16'd4);
        queue_random(4, 260);
        set_window(16'hFFFF);
        queue_random(65535, 260);
        set_window(16'($urandom_range(5, 40)));
        queue_random(win_ticks, 300);
        set_window(WINDOW_RESET);
        queue_random(1000, 200);

        // Drive a stretch with no idling on either side.
        set_window(16'd6);
        no_stall = 1'b1;
        queue_random(6, 60);
        drain();
        no_stall = 1'b0;

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
